// ----- design/mou_pkg.sv -----
package mou_pkg;

  localparam int VEC_W     = 64;
  localparam int DEG_W     = 11;
  localparam int MODE_W    = 3;
  localparam int CNT_W     = 4;
  localparam int MASK_W    = 8;
  localparam int THR_W     = 19;
  localparam int CFG_IDX_W = 3;
  localparam int WGT_SLOT  = 8;

  localparam int DEF_NUM_VARS    = 8;
  localparam int DEF_EXP_BITS    = 8;
  localparam int DEF_WEIGHT_BITS = 8;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [1:0]    sign_t;

  localparam mode_t ORD_LEX     = 3'd0;
  localparam mode_t ORD_GRLEX   = 3'd1;
  localparam mode_t ORD_GREVLEX = 3'd2;
  localparam mode_t ORD_ELIM    = 3'd3;
  localparam mode_t ORD_WEIGHT  = 3'd4;

  localparam cfg_idx_t REG_ORDER_MODE       = 3'd0;
  localparam cfg_idx_t REG_LANE_COUNT       = 3'd1;
  localparam cfg_idx_t REG_ELIM_MASK        = 3'd2;
  localparam cfg_idx_t REG_WEIGHT_ENABLE    = 3'd3;
  localparam cfg_idx_t REG_WEIGHT_VECTOR    = 3'd4;
  localparam cfg_idx_t REG_WEIGHT_THRESHOLD = 3'd5;

  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_NEG  = 2'sb11;

  typedef struct packed {
    logic [VEC_W-1:0] vec_a;
    logic [VEC_W-1:0] vec_b;
  } in_t;

  typedef struct packed {
    sign_t            order_sign;
    logic [VEC_W-1:0] lcm_vec;
    logic [VEC_W-1:0] quotient_vec;
    logic             b_divides_a;
    logic             are_coprime;
    logic [DEG_W-1:0] degree_a;
    logic [DEG_W-1:0] degree_b;
  } out_t;

  typedef struct packed {
    logic [VEC_W-1:0] lcm_vec;
    logic [VEC_W-1:0] quotient_vec;
    logic             b_divides_a;
    logic             are_coprime;
    logic [DEG_W-1:0] degree_a;
    logic [DEG_W-1:0] degree_b;
  } lane_res_t;

  typedef struct packed {
    mode_t            order_mode;
    logic [CNT_W-1:0] lane_count;
    logic [MASK_W-1:0] elim_mask;
    logic             weight_enable;
    logic [VEC_W-1:0] weight_vector;
    logic [THR_W-1:0] weight_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    order_mode:       ORD_GREVLEX,
    lane_count:       4'd8,
    elim_mask:        8'h00,
    weight_enable:    1'b0,
    weight_vector:    64'h0101_0101_0101_0101,
    weight_threshold: 19'd0
  };

endpackage

// ----- design/monomial_order_unit.sv -----
// Monomial order unit.
// Operand channel: present operands (vec_a, vec_b) with start; the transaction
// is taken at a rising edge with start high and busy low. busy is high only
// while rst is asserted, so a new transaction can be taken every cycle.
// Result channel: done is high for one cycle with result valid beside it;
// accepted operands are registered with in_vld, and done rises with the
// result register that in_vld loads. The receiver cannot stall; every
// result must be captured in the cycle done is high.
// Throughput: one transaction per cycle while rst is low; the path is the
// operand register followed by one pass through the lane and order logic
// into the result register.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no transaction is in flight. Unknown indexes are ignored.
// Reset (synchronous, active high): config returns to grevlex, eight lanes,
// no elimination mask, weights disabled with every weight one, threshold
// zero; any transaction in flight is dropped.
module monomial_order_unit
  import mou_pkg::*;
#(
  parameter int NUM_VARS    = DEF_NUM_VARS,
  parameter int EXP_BITS    = DEF_EXP_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_t              operands,
  output logic             done,
  output out_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [VEC_W-1:0] cfg_data
);

  cfg_t                cfg;
  in_t                 operand_reg;
  logic                in_vld;
  logic [NUM_VARS-1:0] used;
  lane_res_t           lane_res;
  sign_t               order_sign;
  out_t                result_next;

  assign busy = rst;

  mou_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mou_lane_ops #(
    .NUM_VARS (NUM_VARS),
    .EXP_BITS (EXP_BITS)
  ) u_lanes (
    .vec_a      (operand_reg.vec_a),
    .vec_b      (operand_reg.vec_b),
    .lane_count (cfg.lane_count),
    .used       (used),
    .res        (lane_res)
  );

  mou_order_cmp #(
    .NUM_VARS    (NUM_VARS),
    .EXP_BITS    (EXP_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_order (
    .vec_a      (operand_reg.vec_a),
    .vec_b      (operand_reg.vec_b),
    .used       (used),
    .degree_a   (lane_res.degree_a),
    .degree_b   (lane_res.degree_b),
    .cfg        (cfg),
    .order_sign (order_sign)
  );

  always_comb begin
    result_next.order_sign   = order_sign;
    result_next.lcm_vec      = lane_res.lcm_vec;
    result_next.quotient_vec = lane_res.quotient_vec;
    result_next.b_divides_a  = lane_res.b_divides_a;
    result_next.are_coprime  = lane_res.are_coprime;
    result_next.degree_a     = lane_res.degree_a;
    result_next.degree_b     = lane_res.degree_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      done   <= in_vld;
    end
    if (start && !busy) begin
      operand_reg <= operands;
    end
    if (in_vld) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_issue_to_done: assert property (@(posedge clk) disable iff (rst)
    in_vld |=> done) else $error("operand stage did not produce a result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_vld)) else $error("result strobe without a transaction");

  a_equal_degrees: assert property (@(posedge clk) disable iff (rst)
    done && result.order_sign == SIGN_ZERO |-> result.degree_a == result.degree_b)
    else $error("equal order with different degrees");

  a_divisor_degree: assert property (@(posedge clk) disable iff (rst)
    done && result.b_divides_a |-> result.degree_a >= result.degree_b)
    else $error("divisor has larger degree");
`endif

endmodule

// ----- design/mou_cfg_regs.sv -----
module mou_cfg_regs
  import mou_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [VEC_W-1:0] cfg_data,
  output cfg_t             cfg
);

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER_MODE:       cfg.order_mode       <= cfg_data[MODE_W-1:0];
        REG_LANE_COUNT:       cfg.lane_count       <= cfg_data[CNT_W-1:0];
        REG_ELIM_MASK:        cfg.elim_mask        <= cfg_data[MASK_W-1:0];
        REG_WEIGHT_ENABLE:    cfg.weight_enable    <= cfg_data[0];
        REG_WEIGHT_VECTOR:    cfg.weight_vector    <= cfg_data;
        REG_WEIGHT_THRESHOLD: cfg.weight_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/mou_lane_ops.sv -----
module mou_lane_ops
  import mou_pkg::*;
#(
  parameter int NUM_VARS = DEF_NUM_VARS,
  parameter int EXP_BITS = DEF_EXP_BITS
) (
  input  logic [VEC_W-1:0]    vec_a,
  input  logic [VEC_W-1:0]    vec_b,
  input  logic [CNT_W-1:0]    lane_count,
  output logic [NUM_VARS-1:0] used,
  output lane_res_t           res
);

  always_comb begin
    logic [EXP_BITS-1:0] a;
    logic [EXP_BITS-1:0] b;
    res = '0;
    res.b_divides_a = 1'b1;
    res.are_coprime = 1'b1;
    for (int i = 0; i < NUM_VARS; i++) begin
      a = vec_a[i*EXP_BITS +: EXP_BITS];
      b = vec_b[i*EXP_BITS +: EXP_BITS];
      used[i] = lane_count > CNT_W'(i);
      if (used[i]) begin
        res.lcm_vec[i*EXP_BITS +: EXP_BITS] = (a > b) ? a : b;
        if (a >= b) begin
          res.quotient_vec[i*EXP_BITS +: EXP_BITS] = a - b;
        end else begin
          res.b_divides_a = 1'b0;
        end
        if (a != '0 && b != '0) begin
          res.are_coprime = 1'b0;
        end
        res.degree_a = res.degree_a + DEG_W'(a);
        res.degree_b = res.degree_b + DEG_W'(b);
      end
    end
  end

endmodule

// ----- design/mou_order_cmp.sv -----
module mou_order_cmp
  import mou_pkg::*;
#(
  parameter int NUM_VARS    = DEF_NUM_VARS,
  parameter int EXP_BITS    = DEF_EXP_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic [VEC_W-1:0]    vec_a,
  input  logic [VEC_W-1:0]    vec_b,
  input  logic [NUM_VARS-1:0] used,
  input  logic [DEG_W-1:0]    degree_a,
  input  logic [DEG_W-1:0]    degree_b,
  input  cfg_t                cfg,
  output sign_t               order_sign
);

  localparam int WSUM_W = EXP_BITS + WEIGHT_BITS + $clog2(NUM_VARS + 1);
  localparam int CMP_W  = (WSUM_W > THR_W) ? WSUM_W : THR_W;

  sign_t lex_sign, rev_sign, deg_sign, elim_sign;
  sign_t grlex_sign, grevlex_sign;
  logic [DEG_W-1:0]  elim_a, elim_b;
  logic [WSUM_W-1:0] wsum_a, wsum_b, wdiff;
  logic              wdecide;

  always_comb begin
    logic [EXP_BITS-1:0] a;
    logic [EXP_BITS-1:0] b;
    logic [WEIGHT_BITS-1:0] w;
    lex_sign = SIGN_ZERO;
    rev_sign = SIGN_ZERO;
    elim_a   = '0;
    elim_b   = '0;
    wsum_a   = '0;
    wsum_b   = '0;
    // lex: lowest differing lane wins, so walk downward
    for (int i = NUM_VARS - 1; i >= 0; i--) begin
      a = vec_a[i*EXP_BITS +: EXP_BITS];
      b = vec_b[i*EXP_BITS +: EXP_BITS];
      if (used[i] && a != b) begin
        lex_sign = (a > b) ? SIGN_POS : SIGN_NEG;
      end
    end
    // reverse lex: highest differing lane wins, smaller exponent is greater
    for (int i = 0; i < NUM_VARS; i++) begin
      a = vec_a[i*EXP_BITS +: EXP_BITS];
      b = vec_b[i*EXP_BITS +: EXP_BITS];
      w = cfg.weight_vector[i*WGT_SLOT +: WEIGHT_BITS];
      if (used[i]) begin
        if (a != b) begin
          rev_sign = (a < b) ? SIGN_POS : SIGN_NEG;
        end
        if (cfg.elim_mask[i]) begin
          elim_a = elim_a + DEG_W'(a);
          elim_b = elim_b + DEG_W'(b);
        end
        wsum_a = wsum_a + WSUM_W'(w * a);
        wsum_b = wsum_b + WSUM_W'(w * b);
      end
    end
  end

  assign deg_sign     = (degree_a > degree_b) ? SIGN_POS :
                        (degree_a < degree_b) ? SIGN_NEG : SIGN_ZERO;
  assign grlex_sign   = (deg_sign != SIGN_ZERO) ? deg_sign : lex_sign;
  assign grevlex_sign = (deg_sign != SIGN_ZERO) ? deg_sign : rev_sign;
  assign elim_sign    = (elim_a > elim_b) ? SIGN_POS :
                        (elim_a < elim_b) ? SIGN_NEG : grevlex_sign;

  assign wdiff   = (wsum_a > wsum_b) ? wsum_a - wsum_b : wsum_b - wsum_a;
  assign wdecide = cfg.weight_enable &&
                   (CMP_W'(wdiff) > CMP_W'(cfg.weight_threshold));

  always_comb begin
    case (cfg.order_mode)
      ORD_LEX:    order_sign = lex_sign;
      ORD_GRLEX:  order_sign = grlex_sign;
      ORD_ELIM:   order_sign = elim_sign;
      ORD_WEIGHT: order_sign = wdecide ? ((wsum_a > wsum_b) ? SIGN_POS : SIGN_NEG)
                                       : grevlex_sign;
      default:    order_sign = grevlex_sign;
    endcase
  end

endmodule

// ----- tb/monomial_order_checker.sv -----
module monomial_order_checker
  import mou_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_t              operands,
  input  logic             done,
  input  out_t             result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [VEC_W-1:0] cfg_data,
  output int               mismatches,
  output int               pending,
  output int               checked,
  output int               n_above,
  output int               n_equal,
  output int               n_below
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV   = DEF_NUM_VARS;
  localparam int LW   = DEF_EXP_BITS;
  localparam int WW   = DEF_WEIGHT_BITS;
  localparam int SHOW = 40;

  typedef int unsigned lanes_t [NV];

  typedef struct packed {
    in_t  operands;
    out_t expected;
  } transaction_t;

  cfg_t         regs;
  transaction_t awaiting_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    n_above    = 0;
    n_equal    = 0;
    n_below    = 0;
    regs       = CFG_RESET;
  end

  function automatic sign_t compare_counts(int unsigned x, int unsigned y);
    return (x > y) ? SIGN_POS : ((x < y) ? SIGN_NEG : SIGN_ZERO);
  endfunction

  // total degree first, then the highest differing lane: smaller exponent wins
  function automatic sign_t grevlex_sign(lanes_t a, lanes_t b, int unsigned n,
                                         int unsigned da, int unsigned db);
    sign_t s;
    int    i;
    if (da != db) return compare_counts(da, db);
    s = SIGN_ZERO;
    for (i = int'(n) - 1; i >= 0; i--)
      if (s == SIGN_ZERO && a[i] != b[i]) s = compare_counts(b[i], a[i]);
    return s;
  endfunction

  function automatic out_t monomial_ops(in_t op, cfg_t c);
    lanes_t      a;
    lanes_t      b;
    out_t        r;
    int unsigned n, da, db, ea, eb, wa, wb, w, diff;
    int          i;
    n = (c.lane_count > NV) ? NV : 32'(c.lane_count);
    r = '0;
    r.b_divides_a = 1'b1;
    r.are_coprime = 1'b1;
    da = 0; db = 0; ea = 0; eb = 0; wa = 0; wb = 0;
    for (i = 0; i < NV; i++) begin
      a[i] = 0;
      b[i] = 0;
    end
    for (i = 0; i < int'(n); i++) begin
      a[i] = 32'(op.vec_a[i*LW +: LW]);
      b[i] = 32'(op.vec_b[i*LW +: LW]);
      w    = 32'(c.weight_vector[i*WGT_SLOT +: WW]);
      da += a[i];
      db += b[i];
      wa += w * a[i];
      wb += w * b[i];
      if (c.elim_mask[i]) begin
        ea += a[i];
        eb += b[i];
      end
      r.lcm_vec[i*LW +: LW] = LW'((a[i] > b[i]) ? a[i] : b[i]);
      if (a[i] >= b[i]) begin
        r.quotient_vec[i*LW +: LW] = LW'(a[i] - b[i]);
      end else begin
        r.b_divides_a = 1'b0;
      end
      if (a[i] != 0 && b[i] != 0) r.are_coprime = 1'b0;
    end
    r.degree_a = da[DEG_W-1:0];
    r.degree_b = db[DEG_W-1:0];
    case (c.order_mode)
      ORD_LEX, ORD_GRLEX: begin
        if (c.order_mode == ORD_GRLEX && da != db) begin
          r.order_sign = compare_counts(da, db);
        end else begin
          for (i = 0; i < int'(n); i++)
            if (r.order_sign == SIGN_ZERO && a[i] != b[i])
              r.order_sign = compare_counts(a[i], b[i]);
        end
      end
      ORD_ELIM: begin
        r.order_sign = (ea != eb) ? compare_counts(ea, eb) : grevlex_sign(a, b, n, da, db);
      end
      ORD_WEIGHT: begin
        diff = (wa > wb) ? wa - wb : wb - wa;
        if (c.weight_enable && diff > 32'(c.weight_threshold)) begin
          r.order_sign = compare_counts(wa, wb);
        end else begin
          r.order_sign = grevlex_sign(a, b, n, da, db);
        end
      end
      default: begin
        r.order_sign = grevlex_sign(a, b, n, da, db);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOW) $display("[%0t] %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [VEC_W-1:0] want, logic [VEC_W-1:0] got,
                               in_t op);
    if (want !== got)
      report_mismatch($sformatf("%s: expected %0h, got %0h (a=%h b=%h)",
                                name, want, got, op.vec_a, op.vec_b));
  endtask

  always @(posedge clk) begin
    transaction_t t;
    if (rst) begin
      regs = CFG_RESET;
      awaiting_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORDER_MODE:       regs.order_mode       = cfg_data[MODE_W-1:0];
          REG_LANE_COUNT:       regs.lane_count       = cfg_data[CNT_W-1:0];
          REG_ELIM_MASK:        regs.elim_mask        = cfg_data[MASK_W-1:0];
          REG_WEIGHT_ENABLE:    regs.weight_enable    = cfg_data[0];
          REG_WEIGHT_VECTOR:    regs.weight_vector    = cfg_data;
          REG_WEIGHT_THRESHOLD: regs.weight_threshold = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        t.operands = operands;
        t.expected = monomial_ops(operands, regs);
        awaiting_results.push_back(t);
      end
      if (done) begin
        if (awaiting_results.size() == 0) begin
          report_mismatch("result arrived with no transaction outstanding");
        end else begin
          t = awaiting_results.pop_front();
          compare_field("order_sign", VEC_W'(t.expected.order_sign),
                        VEC_W'(result.order_sign), t.operands);
          compare_field("lcm_vec", t.expected.lcm_vec, result.lcm_vec, t.operands);
          compare_field("quotient_vec", t.expected.quotient_vec, result.quotient_vec,
                        t.operands);
          compare_field("b_divides_a", VEC_W'(t.expected.b_divides_a),
                        VEC_W'(result.b_divides_a), t.operands);
          compare_field("are_coprime", VEC_W'(t.expected.are_coprime),
                        VEC_W'(result.are_coprime), t.operands);
          compare_field("degree_a", VEC_W'(t.expected.degree_a), VEC_W'(result.degree_a),
                        t.operands);
          compare_field("degree_b", VEC_W'(t.expected.degree_b), VEC_W'(result.degree_b),
                        t.operands);
          checked++;
          if (t.expected.order_sign == SIGN_POS) n_above++;
          else if (t.expected.order_sign == SIGN_NEG) n_below++;
          else n_equal++;
        end
      end
    end
    pending = awaiting_results.size();
  end

endmodule

// ----- tb/tb_monomial_order_unit.sv -----
module tb_monomial_order_unit
  import mou_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES       = DEF_NUM_VARS;
  localparam int LANE_W      = DEF_EXP_BITS;
  localparam int ITEM_TARGET = 1100;
  localparam int PHASE_ITEMS = 40;
  localparam int CYCLE_LIMIT = 500000;

  localparam mode_t    ORD_UNASSIGNED_FIRST = 3'd5;
  localparam mode_t    ORD_UNASSIGNED_LAST  = 3'd7;
  localparam cfg_idx_t REG_UNMAPPED_LO      = 3'd6;
  localparam cfg_idx_t REG_UNMAPPED_HI      = 3'd7;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  in_t              operands;
  logic             done;
  out_t             result;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_idx_t         cfg_index;
  logic [VEC_W-1:0] cfg_data;

  int mismatches, pending, checked, n_above, n_equal, n_below;
  int items_sent  = 0;
  int settings    = 0;
  int reg_writes  = 0;
  int cycle_count = 0;

  in_t corner_cases [12] = '{
    {64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
    {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    {64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000},
    {64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
    {64'h0000_0000_0000_0001, 64'h0100_0000_0000_0000},
    {64'h0100_0000_0000_0000, 64'h0000_0000_0000_0001},
    {64'h0102_0304_0506_0708, 64'h0807_0605_0403_0201},
    {64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00},
    {64'h0505_0505_0505_0505, 64'h0102_0102_0102_0102},
    {64'h0000_0000_0000_0080, 64'h8000_0000_0000_0000},
    {64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080},
    {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}
  };

  always #5 clk = ~clk;

  monomial_order_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operands  (operands),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  monomial_order_checker order_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operands   (operands),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .n_above    (n_above),
    .n_equal    (n_equal),
    .n_below    (n_below)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("monomial_order_unit: mismatch");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [VEC_W-1:0] small_lanes(int maxv);
    logic [VEC_W-1:0] v;
    int               i;
    for (i = 0; i < LANES; i++)
      v[i*LANE_W +: LANE_W] = LANE_W'($urandom_range(0, maxv));
    return v;
  endfunction

  function automatic in_t make_operands();
    in_t         p;
    int          i, j, x;
    logic [7:0]  m;
    logic [LANE_W-1:0] tmp;
    p.vec_a = {$urandom, $urandom};
    p.vec_b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      2, 3: begin
        p.vec_a = small_lanes(3);
        p.vec_b = small_lanes(3);
      end
      4: begin
        if ($urandom_range(0, 1)) p.vec_a = small_lanes(5);
        p.vec_b = p.vec_a;
      end
      5: begin
        // same degree, one unit moved between lanes
        p.vec_a = small_lanes(6);
        p.vec_b = p.vec_a;
        i = $urandom_range(0, LANES - 1);
        j = $urandom_range(0, LANES - 1);
        if (i != j && p.vec_b[i*LANE_W +: LANE_W] != 0) begin
          p.vec_b[i*LANE_W +: LANE_W] = p.vec_b[i*LANE_W +: LANE_W] - LANE_W'(1);
          p.vec_b[j*LANE_W +: LANE_W] = p.vec_b[j*LANE_W +: LANE_W] + LANE_W'(1);
        end
      end
      6: begin
        p.vec_b = small_lanes(40);
        p.vec_a = small_lanes(20);
        for (i = 0; i < LANES; i++)
          p.vec_a[i*LANE_W +: LANE_W] = p.vec_a[i*LANE_W +: LANE_W]
                                      + p.vec_b[i*LANE_W +: LANE_W];
        if ($urandom_range(0, 3) == 0) p = {p.vec_b, p.vec_a};
      end
      7: begin
        m = 8'($urandom_range(0, 255));
        for (i = 0; i < LANES; i++) begin
          if (m[i]) p.vec_b[i*LANE_W +: LANE_W] = '0;
          else p.vec_a[i*LANE_W +: LANE_W] = '0;
        end
      end
      8: begin
        for (i = 0; i < LANES; i++) begin
          x = $urandom_range(0, 3);
          p.vec_a[i*LANE_W +: LANE_W] = LANE_W'((x < 2) ? x : 252 + x);
          x = $urandom_range(0, 3);
          p.vec_b[i*LANE_W +: LANE_W] = LANE_W'((x < 2) ? x : 252 + x);
        end
      end
      9: begin
        // permutation of the same exponents
        p.vec_a = small_lanes(9);
        p.vec_b = p.vec_a;
        i = $urandom_range(0, LANES - 1);
        j = $urandom_range(0, LANES - 1);
        tmp = p.vec_b[i*LANE_W +: LANE_W];
        p.vec_b[i*LANE_W +: LANE_W] = p.vec_b[j*LANE_W +: LANE_W];
        p.vec_b[j*LANE_W +: LANE_W] = tmp;
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic cfg_t make_cfg(mode_t m, logic [CNT_W-1:0] vc, logic [MASK_W-1:0] mask,
                                    logic we, logic [VEC_W-1:0] wv, logic [THR_W-1:0] thr);
    return cfg_t'{m, vc, mask, we, wv, thr};
  endfunction

  function automatic cfg_t make_random_cfg();
    cfg_t c;
    int   r;
    c.order_mode = mode_t'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    c.lane_count = CNT_W'((r < 6) ? 0 :
                          ((r < 12) ? $urandom_range(9, 15) : $urandom_range(1, 8)));
    r = $urandom_range(0, 99);
    c.elim_mask = (r < 20) ? 8'h00 : ((r < 35) ? 8'hFF : MASK_W'($urandom_range(0, 255)));
    c.weight_enable = ($urandom_range(0, 3) != 0);
    c.weight_vector = ($urandom_range(0, 99) < 60) ? {$urandom, $urandom} : small_lanes(3);
    r = $urandom_range(0, 99);
    if (r < 30) c.weight_threshold = '0;
    else if (r < 75) c.weight_threshold = THR_W'($urandom_range(0, 400));
    else if (r < 85) c.weight_threshold = '1;
    else c.weight_threshold = THR_W'($urandom_range(0, 524287));
    return c;
  endfunction

  task automatic send_operands(in_t v, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    operands <= v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [VEC_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // stop sending and let every outstanding transaction come back
  task automatic settle(int extra);
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic run_phase(cfg_t c, int count);
    bit burst;
    int k;
    settle(4);
    write_cfg(REG_ORDER_MODE, VEC_W'(c.order_mode));
    write_cfg(REG_LANE_COUNT, VEC_W'(c.lane_count));
    write_cfg(REG_ELIM_MASK, VEC_W'(c.elim_mask));
    write_cfg(REG_WEIGHT_ENABLE, VEC_W'(c.weight_enable));
    write_cfg(REG_WEIGHT_VECTOR, c.weight_vector);
    write_cfg(REG_WEIGHT_THRESHOLD, VEC_W'(c.weight_threshold));
    write_cfg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, {$urandom, $urandom});
    settings++;
    burst = ($urandom_range(0, 4) == 0);
    for (k = 0; k < count; k++) begin
      if (!burst && $urandom_range(0, 39) == 0) settle(0);
      send_operands(make_operands(), burst ? 0 : idle_gap());
    end
  endtask

  initial begin
    int k;
    rst       = 1'b1;
    start     = 1'b0;
    operands  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORDER_MODE;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    settings++;
    for (k = 0; k < 12; k++) send_operands(corner_cases[k], (k < 6) ? 0 : idle_gap());

    run_phase(make_cfg(ORD_LEX, 8, 8'h00, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_GRLEX, 8, 8'h00, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_GREVLEX, 1, 8'h00, 1'b0, CFG_RESET.weight_vector, '0),
              PHASE_ITEMS);
    run_phase(make_cfg(ORD_ELIM, 8, 8'h00, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_ELIM, 8, 8'hFF, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_ELIM, 3, 8'hF8, 1'b1, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_ELIM, 5, 8'h05, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_WEIGHT, 8, 8'h00, 1'b0, {$urandom, $urandom}, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_WEIGHT, 8, 8'h00, 1'b1, '1, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_WEIGHT, 8, 8'h00, 1'b1, '0, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_WEIGHT, 6, 8'h00, 1'b1, {$urandom, $urandom}, '1), PHASE_ITEMS);
    run_phase(make_cfg(ORD_WEIGHT, 8, 8'h00, 1'b1, small_lanes(3),
                       THR_W'($urandom_range(0, 8))), PHASE_ITEMS);
    run_phase(make_cfg(ORD_UNASSIGNED_FIRST, 15, 8'hFF, 1'b1, '1, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_UNASSIGNED_LAST, 0, 8'hFF, 1'b1, '1, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_LEX, 9, 8'h00, 1'b0, CFG_RESET.weight_vector, '0), PHASE_ITEMS);
    run_phase(make_cfg(ORD_GRLEX, 4, 8'h0F, 1'b1, {$urandom, $urandom}, '1), PHASE_ITEMS);
    while (items_sent < ITEM_TARGET) run_phase(make_random_cfg(), PHASE_ITEMS);

    settle(8);
    $display("%0d operand pairs sent, %0d results checked, %0d register settings, %0d writes",
             items_sent, checked, settings, reg_writes);
    $display("order outcomes: %0d above, %0d equal, %0d below", n_above, n_equal, n_below);
    if (mismatches == 0) begin
      $display("monomial_order_unit: match");
    end else begin
      $display("monomial_order_unit: mismatch");
    end
    $finish;
  end

endmodule
